@@ rtl/hrsp_pkg.sv @@
`timescale 1ns / 1ps

package hrsp_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [31:0] byte_address;
        logic [2:0]  status;
        logic [7:0]  rec_type;
    } out_word_t;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_FMT   = 3'd2;
    localparam logic [2:0] ST_CSUM  = 3'd3;
    localparam logic [2:0] ST_EOF   = 3'd4;

    localparam logic [7:0] REC_DATA  = 8'h00;
    localparam logic [7:0] REC_EOF   = 8'h01;
    localparam logic [7:0] REC_UPPER = 8'h04;

    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_9     = 8'h39;
    localparam logic [7:0] ASCII_UA    = 8'h41;
    localparam logic [7:0] ASCII_UF    = 8'h46;
    localparam logic [7:0] ASCII_LA    = 8'h61;
    localparam logic [7:0] ASCII_LF    = 8'h66;

endpackage

@@ rtl/hex_record_stream_parser_core.sv @@
`timescale 1ns / 1ps

// Intel HEX parser: takes one ASCII character word per cycle and returns at most
// one result word per character, in the cycle after the character is taken, from a
// single output register. in_ready drops only while that register holds a word
// that out_ready has not yet taken. Data words of a type-0 record come out before
// the record's checksum is known; hold them until the record's status word.
// After any error or end-of-file status the core ignores input until reset.
module hex_record_stream_parser_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hrsp_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hrsp_pkg::out_word_t out_data
);

    logic                accept;
    logic                res_valid;
    hrsp_pkg::out_word_t res;
    logic                out_valid_reg;
    hrsp_pkg::out_word_t out_data_reg;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    hrsp_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .word      (in_data),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_data_reg <= res;
        end
    end

endmodule

@@ rtl/hrsp_parse.sv @@
`timescale 1ns / 1ps

module hrsp_parse
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  hrsp_pkg::in_word_t word,
    output logic               res_valid,
    output hrsp_pkg::out_word_t res
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_CSUM,
        PH_TRAIL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  high_reg, high_next;
    logic [1:0]  digit_reg, digit_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  index_reg, index_next;
    logic [15:0] upper_reg, upper_next;
    logic [15:0] pend_reg, pend_next;
    logic        halted_reg, halted_next;

    logic        nib_ok;
    logic [3:0]  nib;
    logic [7:0]  byte_val;
    logic [7:0]  index_inc;
    logic        emit_status;
    logic [2:0]  status_code;
    logic        emit_data;

    always_comb
    begin
        nib_ok = 1'b1;
        nib    = 4'd0;
        if (word.ch >= hrsp_pkg::ASCII_0 && word.ch <= hrsp_pkg::ASCII_9)
        begin
            nib = 4'(word.ch - hrsp_pkg::ASCII_0);
        end
        else if (word.ch >= hrsp_pkg::ASCII_UA && word.ch <= hrsp_pkg::ASCII_UF)
        begin
            nib = 4'(word.ch - hrsp_pkg::ASCII_UA + 8'd10);
        end
        else if (word.ch >= hrsp_pkg::ASCII_LA && word.ch <= hrsp_pkg::ASCII_LF)
        begin
            nib = 4'(word.ch - hrsp_pkg::ASCII_LA + 8'd10);
        end
        else
        begin
            nib_ok = 1'b0;
        end
    end

    assign byte_val  = {high_reg, nib};
    assign index_inc = index_reg + 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        high_next   = high_reg;
        digit_next  = digit_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        type_next   = type_reg;
        sum_next    = sum_reg;
        index_next  = index_reg;
        upper_next  = upper_reg;
        pend_next   = pend_reg;
        halted_next = halted_reg;
        emit_status = 1'b0;
        status_code = hrsp_pkg::ST_OK;
        emit_data   = 1'b0;

        if (step && !halted_reg)
        begin
            unique case (phase_reg) inside
                PH_WAIT:
                begin
                    if (word.ch != hrsp_pkg::ASCII_COLON)
                    begin
                        emit_status = 1'b1;
                        status_code = hrsp_pkg::ST_START;
                    end
                    else
                    begin
                        count_next = '0;
                        addr_next  = '0;
                        type_next  = '0;
                        sum_next   = '0;
                        index_next = '0;
                        pend_next  = '0;
                        digit_next = '0;
                        high_next  = '0;
                        if (word.line_end)
                        begin
                            emit_status = 1'b1;
                            status_code = hrsp_pkg::ST_FMT;
                        end
                        else
                        begin
                            phase_next = PH_COUNT;
                        end
                    end
                end
                PH_TRAIL:
                begin
                    if (word.line_end)
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM:
                begin
                    if (!nib_ok)
                    begin
                        emit_status = 1'b1;
                        status_code = hrsp_pkg::ST_FMT;
                    end
                    else if (!digit_reg[0])
                    begin
                        high_next  = nib;
                        digit_next = digit_reg + 2'd1;
                        if (word.line_end)
                        begin
                            emit_status = 1'b1;
                            status_code = hrsp_pkg::ST_FMT;
                        end
                    end
                    else
                    begin
                        sum_next   = sum_reg + byte_val;
                        digit_next = 2'd0;
                        if (phase_reg == PH_COUNT)
                        begin
                            count_next = byte_val;
                            phase_next = PH_ADDR;
                        end
                        else if (phase_reg == PH_ADDR)
                        begin
                            if (digit_reg == 2'd1)
                            begin
                                addr_next  = {byte_val, 8'h00};
                                digit_next = 2'd2;
                            end
                            else
                            begin
                                addr_next  = {addr_reg[15:8], byte_val};
                                phase_next = PH_TYPE;
                            end
                        end
                        else if (phase_reg == PH_TYPE)
                        begin
                            type_next = byte_val;
                            if (byte_val == hrsp_pkg::REC_EOF)
                            begin
                                emit_status = 1'b1;
                                status_code = hrsp_pkg::ST_EOF;
                            end
                            else
                            begin
                                phase_next = (count_reg == 8'd0) ? PH_CSUM : PH_DATA;
                            end
                        end
                        else if (phase_reg == PH_DATA)
                        begin
                            if (type_reg == hrsp_pkg::REC_UPPER)
                            begin
                                if (index_reg == 8'd0)
                                begin
                                    pend_next = {byte_val, pend_reg[7:0]};
                                end
                                else if (index_reg == 8'd1)
                                begin
                                    pend_next = {pend_reg[15:8], byte_val};
                                end
                            end
                            index_next = index_inc;
                            if (index_inc == count_reg)
                            begin
                                phase_next = PH_CSUM;
                            end
                            if (word.line_end)
                            begin
                                emit_status = 1'b1;
                                status_code = hrsp_pkg::ST_FMT;
                            end
                            else if (type_reg == hrsp_pkg::REC_DATA)
                            begin
                                emit_data = 1'b1;
                            end
                        end
                        else
                        begin
                            if (sum_next != 8'd0)
                            begin
                                emit_status = 1'b1;
                                status_code = hrsp_pkg::ST_CSUM;
                            end
                            else
                            begin
                                if (type_reg == hrsp_pkg::REC_UPPER)
                                begin
                                    upper_next = pend_reg;
                                end
                                phase_next  = word.line_end ? PH_WAIT : PH_TRAIL;
                                emit_status = 1'b1;
                                status_code = hrsp_pkg::ST_OK;
                            end
                        end
                        // early line end on an inner byte
                        if (word.line_end && !emit_status &&
                            (phase_reg == PH_COUNT || phase_reg == PH_ADDR ||
                             phase_reg == PH_TYPE))
                        begin
                            emit_status = 1'b1;
                            status_code = hrsp_pkg::ST_FMT;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase

            if (emit_status && status_code != hrsp_pkg::ST_OK)
            begin
                halted_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        res_valid        = emit_status || emit_data;
        res.kind         = emit_status ? hrsp_pkg::KIND_STATUS : hrsp_pkg::KIND_DATA;
        res.data_byte    = emit_data ? byte_val : 8'h00;
        res.byte_address = emit_data ?
                           ({upper_reg, 16'h0000} + {16'h0000, addr_reg} + {24'h0, index_reg})
                           : 32'h0;
        res.status       = emit_status ? status_code : hrsp_pkg::ST_OK;
        res.rec_type     = type_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            high_reg   <= '0;
            digit_reg  <= '0;
            count_reg  <= '0;
            addr_reg   <= '0;
            type_reg   <= '0;
            sum_reg    <= '0;
            index_reg  <= '0;
            upper_reg  <= '0;
            pend_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            high_reg   <= high_next;
            digit_reg  <= digit_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            type_reg   <= type_next;
            sum_reg    <= sum_next;
            index_reg  <= index_next;
            upper_reg  <= upper_next;
            pend_reg   <= pend_next;
            halted_reg <= halted_next;
        end
    end

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !res_valid)
        else $error("result while halted");

    a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> $stable(upper_reg) && $stable(phase_reg) && halted_reg)
        else $error("state moved while halted");

    a_data_type: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == hrsp_pkg::KIND_DATA |->
            res.rec_type == hrsp_pkg::REC_DATA && phase_reg == PH_DATA)
        else $error("data word outside a data record");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == hrsp_pkg::KIND_STATUS |->
            res.data_byte == 8'h00 && res.byte_address == 32'h0)
        else $error("status word carries data");

    a_ok_resumes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == hrsp_pkg::KIND_STATUS && res.status == hrsp_pkg::ST_OK
            |=> !halted_reg && (phase_reg == PH_WAIT || phase_reg == PH_TRAIL))
        else $error("good record did not return to line scan");

endmodule
